>>> sv/resource_graph_deadlock_detector_core_assert.svh
// Assertion macros for the resource graph deadlock detector.
// Used by resource_graph_deadlock_detector_core.sv; expects clk_i and rst_ni in scope.
`ifndef RESOURCE_GRAPH_DEADLOCK_DETECTOR_CORE_ASSERT_SVH
`define RESOURCE_GRAPH_DEADLOCK_DETECTOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define RGDD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define RGDD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RGDD_ASSERT_IMP(lbl, ante, cons, msg)
`define RGDD_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/rgdd_pkg.sv
// Package for the resource graph deadlock detector: sizes, command codes, types.
// No dependencies.
package rgdd_pkg;

  localparam int TaskCount = 16;
  localparam int ResCount  = 16;
  localparam int TaskW     = $clog2(TaskCount);

  localparam int CmdW      = 3;
  localparam int IdxW      = 4;
  localparam int InDataW   = 16;
  localparam int OutDataW  = 8;

  localparam logic [CmdW-1:0] CMD_REQUEST = 3'd0;
  localparam logic [CmdW-1:0] CMD_HOLD    = 3'd1;
  localparam logic [CmdW-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CmdW-1:0] CMD_REMOVE  = 3'd3;
  localparam logic [CmdW-1:0] CMD_DETECT  = 3'd4;

  typedef logic [TaskCount-1:0][ResCount-1:0] matrix_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

>>> sv/resource_graph_deadlock_detector_core.sv
// Resource graph deadlock detector: held/request matrices, command decode and pruning scan.
// Depends on rgdd_pkg and resource_graph_deadlock_detector_core_assert.svh.
//
// Each input transfer carries one command and produces exactly one output transfer.
// Request, hold, release and remove-resource update the matrices in the cycle of the
// transfer, and their result passes through the done state to the output register.
// Detect runs a pruning scan over the task rows with one shared row unit, one task per
// cycle; the scan repeats passes over all task rows until one changes nothing, at most
// TaskCount + ResCount + 1 passes. The input is not ready while a command is being
// worked on; a finished result waits in the output register, so the next command is
// taken while that result is still pending.
`include "resource_graph_deadlock_detector_core_assert.svh"

module resource_graph_deadlock_detector_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [2:0] cmd, [6:3] task_index, [10:7] resource_index, [15:11] zero
  input  logic [rgdd_pkg::InDataW-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] deadlock_found, [3:1] done_cmd, [7:4] zero
  output logic [rgdd_pkg::OutDataW-1:0] m_axis_tdata
);
  import rgdd_pkg::*;

  state_e state_q, state_d;

  matrix_t held_q, held_d;
  matrix_t req_q, req_d;

  logic [CmdW-1:0] cmd;
  logic [IdxW-1:0] task_idx;
  logic [IdxW-1:0] res_idx;
  logic            in_xfer;
  logic            task_ok;
  logic            res_ok;
  logic [ResCount-1:0] res_bit;

  // Pruning scan state.
  logic [TaskCount-1:0] task_live_q, task_live_d;
  logic [ResCount-1:0]  res_live_q, res_live_d;
  logic [ResCount-1:0]  acc_q, acc_d;
  logic                 killed_q, killed_d;
  logic [TaskW-1:0]     scan_t_q, scan_t_d;

  // Shared row unit.
  logic [TaskW-1:0]    row_addr;
  logic [ResCount-1:0] row_req;
  logic [ResCount-1:0] row_held;
  logic                row_live_new;
  logic [ResCount-1:0] acc_row;
  logic                killed_row;
  logic                pass_end;
  logic [ResCount-1:0] next_res;
  logic                pass_changed;

  logic            found_q, found_d;
  logic [CmdW-1:0] cmd_q, cmd_d;

  logic            out_valid_q, out_valid_d;
  logic            out_found_q, out_found_d;
  logic [CmdW-1:0] out_cmd_q, out_cmd_d;
  logic            out_load;

  assign cmd      = s_axis_tdata[CmdW-1:0];
  assign task_idx = s_axis_tdata[CmdW+IdxW-1:CmdW];
  assign res_idx  = s_axis_tdata[CmdW+2*IdxW-1:CmdW+IdxW];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign task_ok  = int'(task_idx) < TaskCount;
  assign res_ok   = int'(res_idx) < ResCount;

  always_comb begin
    res_bit = '0;
    if (res_ok) begin
      res_bit[res_idx] = 1'b1;
    end
  end

  // One row is read per cycle: the scanned task during a scan, the addressed task otherwise.
  assign row_addr = (state_q == S_SCAN) ? scan_t_q : TaskW'(task_idx);
  assign row_req  = req_q[row_addr];
  assign row_held = held_q[row_addr];

  assign row_live_new = task_live_q[row_addr] && ((row_req & res_live_q) != '0);
  assign acc_row      = row_live_new ? (acc_q | row_held) : acc_q;
  assign killed_row   = killed_q || (task_live_q[row_addr] && !row_live_new);
  assign pass_end     = (scan_t_q == TaskW'(TaskCount - 1));
  assign next_res     = acc_row & res_live_q;
  assign pass_changed = killed_row || (next_res != res_live_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = (cmd == CMD_DETECT) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (pass_end && !pass_changed) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

    held_d      = held_q;
    req_d       = req_q;
    task_live_d = task_live_q;
    res_live_d  = res_live_q;
    acc_d       = acc_q;
    killed_d    = killed_q;
    scan_t_d    = scan_t_q;
    found_d     = found_q;
    cmd_d       = cmd_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_d       = cmd;
          found_d     = 1'b0;
          task_live_d = '1;
          res_live_d  = '1;
          acc_d       = '0;
          killed_d    = 1'b0;
          scan_t_d    = '0;
          case (cmd)
            CMD_REQUEST: begin
              if (task_ok && res_ok) begin
                req_d[row_addr] = row_req | res_bit;
              end
            end
            CMD_HOLD: begin
              if (task_ok && res_ok) begin
                held_d[row_addr] = row_held | res_bit;
                req_d[row_addr]  = row_req & ~res_bit;
              end
            end
            CMD_RELEASE: begin
              if (task_ok && res_ok) begin
                held_d[row_addr] = row_held & ~res_bit;
                req_d[row_addr]  = row_req & ~res_bit;
              end
            end
            CMD_REMOVE: begin
              for (int t = 0; t < TaskCount; t++) begin
                held_d[t] = held_q[t] & ~res_bit;
                req_d[t]  = req_q[t] & ~res_bit;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // A task lives while it requests a live resource; live tasks keep their holdings alive.
        killed_d              = killed_row;
        task_live_d[row_addr] = row_live_new;
        acc_d                 = acc_row;
        if (pass_end) begin
          res_live_d = next_res;
          acc_d      = '0;
          killed_d   = 1'b0;
          scan_t_d   = '0;
          found_d    = (task_live_d != '0) || (next_res != '0);
        end else begin
          scan_t_d = scan_t_q + TaskW'(1);
        end
      end
      default: ;
    endcase

    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_cmd_d   = out_cmd_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_found_d = found_q;
      out_cmd_d   = cmd_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - CmdW - 1){1'b0}}, out_cmd_q, out_found_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      req_q       <= '0;
      out_valid_q <= 1'b0;
      scan_t_q    <= '0;
      killed_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      req_q       <= req_d;
      out_valid_q <= out_valid_d;
      scan_t_q    <= scan_t_d;
      killed_q    <= killed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    task_live_q <= task_live_d;
    res_live_q  <= res_live_d;
    acc_q       <= acc_d;
    found_q     <= found_d;
    cmd_q       <= cmd_d;
    out_found_q <= out_found_d;
    out_cmd_q   <= out_cmd_d;
  end

  `RGDD_ASSERT_NXT(a_scan_keeps_matrices, state_q == S_SCAN,
                   $stable(held_q) && $stable(req_q), "matrices changed during a detect scan")
  `RGDD_ASSERT_NXT(a_update_goes_done, in_xfer && (cmd != CMD_DETECT), state_q == S_DONE,
                   "update command did not complete in one cycle")
  `RGDD_ASSERT_IMP(a_found_only_detect, out_valid_q && out_found_q, out_cmd_q == CMD_DETECT,
                   "deadlock flagged for a command other than detect")
  `RGDD_ASSERT_NXT(a_res_live_shrinks, (state_q == S_SCAN) && (state_d == S_SCAN),
                   (res_live_q & ~$past(res_live_q)) == '0, "live resource set grew during a scan")

endmodule
